>>> src/imwm_pkg.sv
`default_nettype none
package imwm_pkg;

   localparam int PRICE_W = 32;
   localparam int MID_W   = 33;
   localparam int SUM_W   = 34;
   localparam int WIN_W   = 6;
   localparam int SEEN_W  = 8;
   localparam int SCAN_W  = 7;
   localparam int CSR_W   = 2;

   localparam logic [CSR_W-1:0] CSR_SHORT_WINDOW  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_MEDIUM_WINDOW = 2'd1;
   localparam logic [CSR_W-1:0] CSR_LONG_WINDOW   = 2'd2;

   localparam logic [WIN_W-1:0] SHORT_RESET  = 6'd9;
   localparam logic [WIN_W-1:0] MEDIUM_RESET = 6'd26;
   localparam logic [WIN_W-1:0] LONG_RESET   = 6'd52;

   // Steering for the shared compare unit, one entry of history per cycle.
   typedef struct packed {
      logic clear;
      logic take;
      logic in_conv;
      logic in_base;
      logic in_span;
   } scan_ctrl_type;

endpackage
`default_nettype wire

>>> src/imwm_ram.sv
`default_nettype none
module imwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/imwm_extreme_unit.sv
`default_nettype none
module imwm_extreme_unit (
   input  wire logic                           clock,
   input  wire imwm_pkg::scan_ctrl_type        ctrl,
   input  wire logic [imwm_pkg::PRICE_W-1:0]   rd_high,
   input  wire logic [imwm_pkg::PRICE_W-1:0]   rd_low,
   output logic      [imwm_pkg::MID_W-1:0]     conv_x2,
   output logic      [imwm_pkg::MID_W-1:0]     base_x2,
   output logic      [imwm_pkg::MID_W-1:0]     span_b_x2
);
   import imwm_pkg::*;

   logic [PRICE_W-1:0] conv_hi_ff, conv_lo_ff, base_hi_ff, base_lo_ff;
   logic [PRICE_W-1:0] span_hi_ff, span_lo_ff;
   logic [PRICE_W-1:0] conv_hi_in, conv_lo_in, base_hi_in, base_lo_in;
   logic [PRICE_W-1:0] span_hi_in, span_lo_in;

   always_comb begin
      conv_hi_in = conv_hi_ff;
      conv_lo_in = conv_lo_ff;
      base_hi_in = base_hi_ff;
      base_lo_in = base_lo_ff;
      span_hi_in = span_hi_ff;
      span_lo_in = span_lo_ff;
      if (ctrl.clear) begin
         conv_hi_in = '0;
         conv_lo_in = '1;
         base_hi_in = '0;
         base_lo_in = '1;
         span_hi_in = '0;
         span_lo_in = '1;
      end else if (ctrl.take) begin
         if (ctrl.in_conv) begin
            if (rd_high > conv_hi_ff) conv_hi_in = rd_high;
            if (rd_low < conv_lo_ff) conv_lo_in = rd_low;
         end
         if (ctrl.in_base) begin
            if (rd_high > base_hi_ff) base_hi_in = rd_high;
            if (rd_low < base_lo_ff) base_lo_in = rd_low;
         end
         if (ctrl.in_span) begin
            if (rd_high > span_hi_ff) span_hi_in = rd_high;
            if (rd_low < span_lo_ff) span_lo_in = rd_low;
         end
      end
   end

   always_ff @(posedge clock) begin
      conv_hi_ff <= conv_hi_in;
      conv_lo_ff <= conv_lo_in;
      base_hi_ff <= base_hi_in;
      base_lo_ff <= base_lo_in;
      span_hi_ff <= span_hi_in;
      span_lo_ff <= span_lo_in;
   end

   assign conv_x2   = {1'b0, conv_hi_ff} + {1'b0, conv_lo_ff};
   assign base_x2   = {1'b0, base_hi_ff} + {1'b0, base_lo_ff};
   assign span_b_x2 = {1'b0, span_hi_ff} + {1'b0, span_lo_ff};

endmodule
`default_nettype wire

>>> src/ichimoku_window_midpoints.sv
// Ichimoku window midpoints over a stream of candles.
// The req_ channel takes one candle (high, low) per item. The rsp_ channel
// gives conversion and base doubled, span A quadrupled and span B doubled,
// once the history covers every look-back in use; earlier candles give no
// result. The csr_ port writes the short, medium and long windows (6 bits
// each) with a single-cycle write enable; index 3 is ignored.
// After an item is taken the block scans its history one entry per cycle
// through a single registered read port and one set of max/min comparators:
// max(short, medium) + 1 entries, or max(short, medium + long) + 1 when a
// result is due; a drain state and then a done state follow the scan.
// The next item is taken as soon as the block returns to idle.
// The result sits in an output register; a stalled receiver holds the block
// at the end of the following item only, and only if that item also has a
// result to give. Reset is synchronous: windows return to 9, 26 and 52, the
// history is emptied logically (no memory sweep is needed) and any result not
// yet taken is dropped.
`default_nettype none
module ichimoku_window_midpoints #(
   parameter int HISTORY_DEPTH = 128
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [imwm_pkg::PRICE_W-1:0]   req_price_high,
   input  wire logic [imwm_pkg::PRICE_W-1:0]   req_price_low,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [imwm_pkg::MID_W-1:0]     rsp_conversion_x2,
   output logic      [imwm_pkg::MID_W-1:0]     rsp_base_x2,
   output logic      [imwm_pkg::SUM_W-1:0]     rsp_span_a_x4,
   output logic      [imwm_pkg::MID_W-1:0]     rsp_span_b_x2,
   input  wire logic                           csr_write_en,
   input  wire logic [imwm_pkg::CSR_W-1:0]     csr_index,
   input  wire logic [imwm_pkg::WIN_W-1:0]     csr_write_data
);
   import imwm_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_type;

   state_type          state_ff, state_in;
   logic [WIN_W-1:0]   short_ff, short_in, medium_ff, medium_in, long_ff, long_in;
   logic [SEEN_W-1:0]  seen_ff, seen_in;
   logic [AW-1:0]      write_slot_ff, write_slot_in;
   logic [SCAN_W-1:0]  k_ff, k_in, last_ff, last_in, dk_ff, dk_in;
   logic               emit_ff, emit_in, dv_ff, dv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MID_W-1:0]   conv_out_ff, conv_out_in, base_out_ff, base_out_in;
   logic [MID_W-1:0]   spanb_out_ff, spanb_out_in;
   logic [SUM_W-1:0]   spana_out_ff, spana_out_in;

   logic               accept, out_stall, done_go;
   logic [SEEN_W-1:0]  seen_next;
   logic [SCAN_W-1:0]  need, need_lm, need_mm, need_ms, last_base, span_end;
   logic               emit_calc;
   logic [AW-1:0]      hl_rd_addr, mid_rd_addr;
   logic [2*PRICE_W-1:0] hl_rd_data;
   logic [SUM_W-1:0]   mid_rd_data, mid_now;
   logic [MID_W-1:0]   conv_x2, base_x2, span_b_x2;
   scan_ctrl_type      scan_ctrl;

   // Slot a given distance behind the current one, modulo the ring depth.
   function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] slot,
                                               input logic [AW-1:0] back);
      logic [AW:0] diff;
      diff = {1'b0, slot} - {1'b0, back};
      if (diff[AW]) begin
         diff = diff + (AW+1)'(HISTORY_DEPTH);
      end
      return diff[AW-1:0];
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_stall = emit_ff && rsp_valid_ff && !rsp_ready;
   assign done_go   = (state_ff == ST_DONE) && !out_stall;

   assign seen_next = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
   assign need_lm   = SCAN_W'(long_ff) + SCAN_W'(medium_ff);
   assign need_mm   = SCAN_W'(medium_ff) + SCAN_W'(medium_ff);
   assign need_ms   = SCAN_W'(medium_ff) + SCAN_W'(short_ff);
   assign span_end  = need_lm;

   always_comb begin
      need = need_lm;
      if (need_mm > need) need = need_mm;
      if (need_ms > need) need = need_ms;
   end

   assign emit_calc = (int'(need) < HISTORY_DEPTH) && ({1'b0, need} < seen_next);
   assign last_base = (short_ff > medium_ff) ? SCAN_W'(short_ff) : SCAN_W'(medium_ff);

   assign hl_rd_addr  = slot_back(write_slot_ff, AW'(k_ff));
   assign mid_rd_addr = slot_back(write_slot_ff, AW'(medium_ff));

   imwm_ram #(.WIDTH(2*PRICE_W), .DEPTH(HISTORY_DEPTH)) u_hl_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (write_slot_ff),
      .wr_data ({req_price_high, req_price_low}),
      .rd_addr (hl_rd_addr),
      .rd_data (hl_rd_data)
   );

   imwm_ram #(.WIDTH(SUM_W), .DEPTH(HISTORY_DEPTH)) u_mid_ram (
      .clock   (clock),
      .wr_en   (done_go),
      .wr_addr (write_slot_ff),
      .wr_data (mid_now),
      .rd_addr (mid_rd_addr),
      .rd_data (mid_rd_data)
   );

   // Window membership of the entry whose data has just come back.
   always_comb begin
      scan_ctrl.clear   = accept;
      scan_ctrl.take    = dv_ff;
      scan_ctrl.in_conv = (dk_ff <= SCAN_W'(short_ff)) && ({1'b0, dk_ff} < seen_ff);
      scan_ctrl.in_base = (dk_ff <= SCAN_W'(medium_ff)) && ({1'b0, dk_ff} < seen_ff);
      scan_ctrl.in_span = emit_ff && (dk_ff >= SCAN_W'(medium_ff)) && (dk_ff <= span_end);
   end

   imwm_extreme_unit u_extreme (
      .clock     (clock),
      .ctrl      (scan_ctrl),
      .rd_high   (hl_rd_data[2*PRICE_W-1:PRICE_W]),
      .rd_low    (hl_rd_data[PRICE_W-1:0]),
      .conv_x2   (conv_x2),
      .base_x2   (base_x2),
      .span_b_x2 (span_b_x2)
   );

   assign mid_now = {1'b0, conv_x2} + {1'b0, base_x2};

   always_comb begin
      state_in      = state_ff;
      short_in      = short_ff;
      medium_in     = medium_ff;
      long_in       = long_ff;
      seen_in       = seen_ff;
      write_slot_in = write_slot_ff;
      k_in          = k_ff;
      last_in       = last_ff;
      emit_in       = emit_ff;
      dv_in         = 1'b0;
      dk_in         = k_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      conv_out_in   = conv_out_ff;
      base_out_in   = base_out_ff;
      spana_out_in  = spana_out_ff;
      spanb_out_in  = spanb_out_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SHORT_WINDOW:  short_in  = csr_write_data;
            CSR_MEDIUM_WINDOW: medium_in = csr_write_data;
            CSR_LONG_WINDOW:   long_in   = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               seen_in  = seen_next;
               emit_in  = emit_calc;
               k_in     = '0;
               last_in  = (emit_calc && (span_end > last_base)) ? span_end : last_base;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            dv_in = 1'b1;
            if (k_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_stall) begin
               if (emit_ff) begin
                  rsp_valid_in = 1'b1;
                  conv_out_in  = conv_x2;
                  base_out_in  = base_x2;
                  spanb_out_in = span_b_x2;
                  // With no displacement span A is the sum just formed.
                  spana_out_in = (medium_ff == '0) ? mid_now : mid_rd_data;
               end
               write_slot_in = (write_slot_ff == AW'(HISTORY_DEPTH - 1)) ? '0
                                                     : write_slot_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      last_ff      <= last_in;
      dk_ff        <= dk_in;
      conv_out_ff  <= conv_out_in;
      base_out_ff  <= base_out_in;
      spana_out_ff <= spana_out_in;
      spanb_out_ff <= spanb_out_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         short_ff      <= SHORT_RESET;
         medium_ff     <= MEDIUM_RESET;
         long_ff       <= LONG_RESET;
         seen_ff       <= '0;
         write_slot_ff <= '0;
         emit_ff       <= 1'b0;
         dv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         short_ff      <= short_in;
         medium_ff     <= medium_in;
         long_ff       <= long_in;
         seen_ff       <= seen_in;
         write_slot_ff <= write_slot_in;
         emit_ff       <= emit_in;
         dv_ff         <= dv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_conversion_x2 = conv_out_ff;
   assign rsp_base_x2       = base_out_ff;
   assign rsp_span_a_x4     = spana_out_ff;
   assign rsp_span_b_x2     = spanb_out_ff;

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (k_ff <= last_ff))
      else $error("scan index ran past its end");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      int'(write_slot_ff) < HISTORY_DEPTH)
      else $error("write slot outside the ring");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff == ST_DONE) && $past(emit_ff)))
      else $error("result raised outside completion of an item");

   a_busy_seen: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (seen_ff != '0))
      else $error("item in progress with empty history");

endmodule
`default_nettype wire
